>>> sv/fixed_point_alu_q24_8_core_macros.svh
// ----------------------------------------------------------------------------
// Fixed-point ALU assertion macros
// Shared concurrent assertion forms, clocked on clk and quiet during reset.
// ----------------------------------------------------------------------------
`ifndef FIXED_POINT_ALU_Q24_8_CORE_MACROS_SVH
`define FIXED_POINT_ALU_Q24_8_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FPALU_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FPALU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/fpalu_pkg.sv
// ----------------------------------------------------------------------------
// Fixed-point ALU package
// Opcodes, request and response types and sizing constants of the ALU core.
// ----------------------------------------------------------------------------
package fpalu_pkg;

	localparam int FRAC_BITS = 8;
	localparam int DATA_W    = 32;
	// Width of the scaled dividend magnitude.
	localparam int DIV_W     = DATA_W + FRAC_BITS;
	// Quotient bits resolved in each divider stage.
	localparam int DIV_STEPS = 2;
	localparam int DIV_STGS  = (DIV_W + DIV_STEPS - 1) / DIV_STEPS;

	typedef enum logic [3:0] {
		OP_ADD      = 4'd0,
		OP_SUB      = 4'd1,
		OP_MUL      = 4'd2,
		OP_DIV      = 4'd3,
		OP_GT       = 4'd4,
		OP_LT       = 4'd5,
		OP_GE       = 4'd6,
		OP_LE       = 4'd7,
		OP_EQ       = 4'd8,
		OP_NE       = 4'd9,
		OP_MIN      = 4'd10,
		OP_MAX      = 4'd11,
		OP_INC      = 4'd12,
		OP_DEC      = 4'd13,
		OP_TO_INT   = 4'd14,
		OP_FROM_INT = 4'd15
	} alu_op_t;

	typedef struct packed {
		alu_op_t                   kind;
		logic signed [DATA_W-1:0]  operand_a;
		logic signed [DATA_W-1:0]  operand_b;
	} alu_req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0]  result_raw;
		logic                      compare_true;
		logic                      status;
	} alu_rsp_t;

endpackage

>>> sv/fixed_point_alu_q24_8_core.sv
// ----------------------------------------------------------------------------
// Fixed-point ALU core (Q24.8)
// Signed fixed-point arithmetic, comparison and conversion in one pipeline.
// ----------------------------------------------------------------------------
// Every request passes through the same pipeline (the entry stage, the
// divider stages, then the done and rsp registers) and its response appears
// with done. A new request is accepted in every cycle, so busy stays low.
// The pipeline depth is set by the restoring divider, which resolves two
// of the 40 quotient bits in each stage. Responses are held on rsp until the
// next one arrives, but done marks each for a single cycle only, and the
// receiver has no way to hold a response off: it must take it in that cycle.
`include "fixed_point_alu_q24_8_core_macros.svh"

module fixed_point_alu_q24_8_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  fpalu_pkg::alu_req_t  req,
	output logic                 done,
	output fpalu_pkg::alu_rsp_t  rsp
);

	localparam int DW = fpalu_pkg::DIV_W;
	localparam int W  = fpalu_pkg::DATA_W;
	localparam int NS = fpalu_pkg::DIV_STGS;
	localparam int F  = fpalu_pkg::FRAC_BITS;

	// Index 0 is the entry stage, indices 1 to NS the divider stages.
	logic                valid_s [NS+1];
	fpalu_pkg::alu_op_t  kind_s  [NS+1];
	logic signed [W-1:0] res_s   [NS+1];
	logic                cmp_s   [NS+1];
	logic                negq_s  [NS+1];
	logic                dz_s    [NS+1];
	logic [W-1:0]        bmag_s  [NS+1];
	logic [W-1:0]        rem_s   [NS+1];
	logic [DW-1:0]       dq_s    [NS+1];
	logic signed [2*W-1:0] prod_s1;

	logic signed [W-1:0] a_c, b_c, res_c;
	logic                gt_c, eq_c, cmp_c;
	logic [W-1:0]        amag_c, bmag_c;
	logic signed [2*W-1:0] prod_c;
	logic signed [2*W-1:0] mbias_c;
	logic signed [W-1:0] mulres_c;
	logic [W-1:0]        q_c;
	logic signed [W-1:0] divres_c;

	assign busy = 1'b0;

	// Entry stage: the simple operations, the product and the divider set-up.
	always_comb begin
		a_c    = req.operand_a;
		b_c    = req.operand_b;
		gt_c   = a_c > b_c;
		eq_c   = a_c == b_c;
		amag_c = a_c[W-1] ? W'(-a_c) : W'(a_c);
		bmag_c = b_c[W-1] ? W'(-b_c) : W'(b_c);
		prod_c = (2*W)'(a_c) * (2*W)'(b_c);
		res_c  = '0;
		cmp_c  = 1'b0;
		case (req.kind)
			fpalu_pkg::OP_ADD:      res_c = a_c + b_c;
			fpalu_pkg::OP_SUB:      res_c = a_c - b_c;
			fpalu_pkg::OP_GT:       cmp_c = gt_c;
			fpalu_pkg::OP_LT:       cmp_c = !gt_c && !eq_c;
			fpalu_pkg::OP_GE:       cmp_c = gt_c || eq_c;
			fpalu_pkg::OP_LE:       cmp_c = !gt_c;
			fpalu_pkg::OP_EQ:       cmp_c = eq_c;
			fpalu_pkg::OP_NE:       cmp_c = !eq_c;
			fpalu_pkg::OP_MIN:      res_c = gt_c ? b_c : a_c;
			fpalu_pkg::OP_MAX:      res_c = gt_c ? a_c : b_c;
			fpalu_pkg::OP_INC:      res_c = a_c + W'(1);
			fpalu_pkg::OP_DEC:      res_c = a_c - W'(1);
			fpalu_pkg::OP_TO_INT:   res_c = a_c >>> F;
			fpalu_pkg::OP_FROM_INT: res_c = a_c <<< F;
			default:                res_c = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s[0] <= 1'b0;
		end else begin
			valid_s[0] <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		kind_s[0] <= req.kind;
		res_s[0]  <= res_c;
		cmp_s[0]  <= cmp_c;
		negq_s[0] <= a_c[W-1] ^ b_c[W-1];
		dz_s[0]   <= b_c == '0;
		bmag_s[0] <= bmag_c;
		rem_s[0]  <= '0;
		dq_s[0]   <= {amag_c, F'(0)};
		prod_s1   <= prod_c;
	end

	// Product scaled down by the fraction bits, truncated toward zero.
	always_comb begin
		mbias_c  = prod_s1 + (prod_s1[2*W-1] ? (2*W)'((64'd1 << F) - 64'd1) : '0);
		mulres_c = W'(mbias_c >>> F);
	end

	for (genvar k = 1; k <= NS; k++) begin : g_div
		logic [W-1:0]        rem_c;
		logic [DW-1:0]       dq_c;
		logic [W:0]          sh_c;
		logic signed [W-1:0] res_in;

		// Restoring division: the dividend shifts out at the top of dq while
		// quotient bits shift in at the bottom.
		always_comb begin
			rem_c  = rem_s[k-1];
			dq_c   = dq_s[k-1];
			sh_c   = '0;
			res_in = res_s[k-1];
			if (k == 1 && kind_s[0] == fpalu_pkg::OP_MUL) begin
				res_in = mulres_c;
			end
			for (int j = 0; j < fpalu_pkg::DIV_STEPS; j++) begin
				if ((k - 1) * fpalu_pkg::DIV_STEPS + j < DW) begin
					sh_c = {rem_c, dq_c[DW-1]};
					if (sh_c >= {1'b0, bmag_s[k-1]}) begin
						rem_c = W'(sh_c - {1'b0, bmag_s[k-1]});
						dq_c  = {dq_c[DW-2:0], 1'b1};
					end else begin
						rem_c = sh_c[W-1:0];
						dq_c  = {dq_c[DW-2:0], 1'b0};
					end
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else begin
				valid_s[k] <= valid_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			kind_s[k] <= kind_s[k-1];
			res_s[k]  <= res_in;
			cmp_s[k]  <= cmp_s[k-1];
			negq_s[k] <= negq_s[k-1];
			dz_s[k]   <= dz_s[k-1];
			bmag_s[k] <= bmag_s[k-1];
			rem_s[k]  <= rem_c;
			dq_s[k]   <= dq_c;
		end
	end

	// Only the low word of the quotient survives the wrap to 32 bits.
	always_comb begin
		q_c      = dq_s[NS][W-1:0];
		divres_c = negq_s[NS] ? W'(-q_c) : W'(q_c);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= valid_s[NS];
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s[NS]) begin
			if (kind_s[NS] == fpalu_pkg::OP_DIV) begin
				rsp.result_raw <= dz_s[NS] ? '0 : divres_c;
				rsp.status     <= dz_s[NS];
			end else begin
				rsp.result_raw <= res_s[NS];
				rsp.status     <= 1'b0;
			end
			rsp.compare_true <= cmp_s[NS];
		end
	end

	`FPALU_ASSERT_NEXT(a_take, start && !busy, valid_s[0], "accepted request not captured")
	`FPALU_ASSERT_NEXT(a_emit, valid_s[NS], done, "request lost at pipeline end")
	`FPALU_ASSERT_SAME(a_dz, done && rsp.status,
		rsp.result_raw == '0 && !rsp.compare_true, "division by zero with a result")
	`FPALU_ASSERT_SAME(a_cmp, done && rsp.compare_true,
		rsp.result_raw == '0 && !rsp.status, "comparison with a raw result")

endmodule

>>> test/fixed_point_alu_q24_8_core_tb.sv
// ----------------------------------------------------------------------------
// Fixed-point ALU core testbench
// Drives directed and random requests through the ALU under several idling
// patterns and checks every response against a built-in arithmetic predictor.
// ----------------------------------------------------------------------------
module fixed_point_alu_q24_8_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LATENCY = fpalu_pkg::DIV_STGS + 2;

	// Expected responses, oldest first, with the prediction for each request.
	class alu_scoreboard;
		fpalu_pkg::alu_rsp_t pending[$];
		int                  errors;

		function fpalu_pkg::alu_rsp_t predict(fpalu_pkg::alu_req_t r);
			fpalu_pkg::alu_rsp_t o;
			logic signed [63:0]  a, b, p;
			o = '0;
			a = r.operand_a;
			b = r.operand_b;
			case (r.kind)
				fpalu_pkg::OP_ADD: o.result_raw = 32'(a + b);
				fpalu_pkg::OP_SUB: o.result_raw = 32'(a - b);
				fpalu_pkg::OP_MUL: begin
					p = a * b;
					// Truncate toward zero, as the signed 64-bit division does.
					p = p / (64'sd1 <<< fpalu_pkg::FRAC_BITS);
					o.result_raw = p[31:0];
				end
				fpalu_pkg::OP_DIV: begin
					if (b == 0) begin
						o.status = 1'b1;
					end else begin
						p = (a <<< fpalu_pkg::FRAC_BITS) / b;
						o.result_raw = p[31:0];
					end
				end
				fpalu_pkg::OP_GT:  o.compare_true = a > b;
				fpalu_pkg::OP_LT:  o.compare_true = a < b;
				fpalu_pkg::OP_GE:  o.compare_true = a >= b;
				fpalu_pkg::OP_LE:  o.compare_true = a <= b;
				fpalu_pkg::OP_EQ:  o.compare_true = a == b;
				fpalu_pkg::OP_NE:  o.compare_true = a != b;
				fpalu_pkg::OP_MIN: o.result_raw = 32'((a > b) ? b : a);
				fpalu_pkg::OP_MAX: o.result_raw = 32'((a > b) ? a : b);
				fpalu_pkg::OP_INC: o.result_raw = 32'(a + 1);
				fpalu_pkg::OP_DEC: o.result_raw = 32'(a - 1);
				fpalu_pkg::OP_TO_INT:
					o.result_raw = r.operand_a >>> fpalu_pkg::FRAC_BITS;
				fpalu_pkg::OP_FROM_INT:
					o.result_raw = r.operand_a << fpalu_pkg::FRAC_BITS;
				default: o = '0;
			endcase
			return o;
		endfunction

		function void note_request(fpalu_pkg::alu_req_t r);
			pending.push_back(predict(r));
		endfunction

		function void check_response(fpalu_pkg::alu_rsp_t got);
			fpalu_pkg::alu_rsp_t want;
			if (pending.size() == 0) begin
				$error("unexpected response result_raw=%0d", got.result_raw);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.result_raw !== want.result_raw) begin
				$error("result_raw: expected %0d, got %0d", want.result_raw, got.result_raw);
				errors++;
			end
			if (got.compare_true !== want.compare_true) begin
				$error("compare_true: expected %0b, got %0b", want.compare_true,
					got.compare_true);
				errors++;
			end
			if (got.status !== want.status) begin
				$error("status: expected %0b, got %0b", want.status, got.status);
				errors++;
			end
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	fpalu_pkg::alu_req_t req;
	logic                done;
	fpalu_pkg::alu_rsp_t rsp;

	alu_scoreboard board;
	int            idle_pct;

	fixed_point_alu_q24_8_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.rsp    (rsp)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		if (arst_n && start && !busy)
			board.note_request(req);
		if (arst_n && done)
			board.check_response(rsp);
	end

	// Issues one request at the falling edge and holds it until it is taken.
	// The caller lowers start once the last request has gone.
	task automatic send_request(fpalu_pkg::alu_op_t kind, logic [31:0] a, logic [31:0] b);
		while (idle_pct > 0 && $urandom_range(99, 0) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start         <= 1'b1;
		req.kind      <= kind;
		req.operand_a <= a;
		req.operand_b <= b;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic [31:0] random_operand();
		case ($urandom_range(5, 0))
			0: return $urandom_range(2047, 0) - 1024;
			1: return {$urandom_range(1, 0) ? 8'hff : 8'h00, 24'($urandom)};
			2: return $urandom_range(4, 0) == 0 ? 32'h0 : 32'h8000_0000 ^ $urandom_range(1, 0);
			default: return $urandom;
		endcase
	endfunction

	initial begin
		#10ms;
		$display("** fixed_point_alu_q24_8_core: FAILED **");
		$finish;
	end

	initial begin
		logic [31:0]        edges [6];
		fpalu_pkg::alu_op_t kind;
		board    = new();
		idle_pct = 0;
		start    = 1'b0;
		req      = '0;
		arst_n   = 1'b0;
		edges    = '{32'h0, 32'h1, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h100};
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		// Every operation once on extremes, then division by zero and overflows.
		for (int k = 0; k < 16; k++) begin
			kind = fpalu_pkg::alu_op_t'(k);
			send_request(kind, edges[k % 6], edges[(k + 3) % 6]);
		end
		send_request(fpalu_pkg::OP_DIV, 32'h0000_0500, 32'h0);
		send_request(fpalu_pkg::OP_DIV, 32'h8000_0000, 32'hffff_ffff);
		send_request(fpalu_pkg::OP_MUL, 32'h7fff_ffff, 32'h7fff_ffff);
		send_request(fpalu_pkg::OP_MUL, 32'hffff_ff80, 32'h0000_0001);
		send_request(fpalu_pkg::OP_ADD, 32'h7fff_ffff, 32'h1);
		send_request(fpalu_pkg::OP_INC, 32'h7fff_ffff, 32'h0);
		send_request(fpalu_pkg::OP_DEC, 32'h8000_0000, 32'h0);
		send_request(fpalu_pkg::OP_TO_INT, 32'hffff_ff01, 32'h0);
		send_request(fpalu_pkg::OP_EQ, 32'h8000_0000, 32'h8000_0000);

		for (int phase = 0; phase < 4; phase++) begin
			idle_pct = (phase == 1) ? 67 : (phase == 3) ? 17 : 0;
			for (int n = 0; n < 400; n++) begin
				kind = fpalu_pkg::alu_op_t'($urandom_range(15, 0));
				send_request(kind, random_operand(), random_operand());
			end
		end
		start <= 1'b0;

		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
		if (board.errors == 0)
			$display("** fixed_point_alu_q24_8_core: PASSED **");
		else
			$display("** fixed_point_alu_q24_8_core: FAILED **");
		$finish;
	end
endmodule

>>> fixed_point_alu_q24_8_core.f
+incdir+sv
sv/fpalu_pkg.sv
sv/fixed_point_alu_q24_8_core.sv
test/fixed_point_alu_q24_8_core_tb.sv
